/* sv/cht_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// shared constants, types and command structs of the chained hash table
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int BUCKETS     = 16;
    localparam int NODES       = 64;
    localparam int BIDX_W      = $clog2(BUCKETS);
    localparam int NIDX_W      = $clog2(NODES);
    localparam int LINK_W      = NIDX_W + 1;
    localparam int CNT_W       = NIDX_W + 1;
    localparam int KEY_W       = 31;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int BCNT_W      = 5;
    localparam int BUCKET_W    = 4;
    localparam int POS_W       = 6;
    localparam int BCNT_RESET  = 9;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic mod_step;   // one restoring division step
        logic head_rd;    // read bucket head to cursor
        logic node_rd;    // issue read of node at cursor
        logic walk;       // advance cursor after node read
        logic link_tail;  // link new node behind chain tail
        logic do_insert;  // commit insert
        logic do_delete;  // commit delete
        logic fin;        // capture status and position
        logic set_result;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic cur_nil;
        logic next_nil;
        logic key_match;
        logic pool_empty;
        logic step_limit;
        logic [FUNC_W-1:0] func;
    } t_stat;

endpackage
`default_nettype wire

/* sv/cht_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ctrl
// request sequencer: hash, chain walk and commit of one request at a time
// ----------------------------------------------------------------------------
module cht_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_fire,
    input  wire logic          i_out_free,
    input  wire cht_pkg::t_stat i_stat,
    output logic               o_busy,
    output cht_pkg::t_cmd      o_cmd
);
    import cht_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_INS  = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_req_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_stat.func == FN_NONE) begin
                    n_state = S_IDLE;
                end else if (i_stat.mod_done) begin
                    n_state = S_HEAD;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_HEAD: begin
                if (i_stat.func == FN_INSERT && i_stat.pool_empty) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.head_rd = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.cur_nil) begin
                    if (i_stat.func == FN_INSERT) begin
                        n_state = S_INS;
                    end else begin
                        o_cmd.fin    = 1'b1;
                        o_cmd.status = ST_NOTFOUND;
                        n_state      = S_DONE;
                    end
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.func == FN_INSERT) begin
                    if (i_stat.next_nil || i_stat.step_limit) begin
                        o_cmd.link_tail = 1'b1;
                        n_state         = S_INS;
                    end else begin
                        o_cmd.walk = 1'b1;
                        n_state    = S_RD;
                    end
                end else if (i_stat.key_match) begin
                    o_cmd.do_delete = (i_stat.func == FN_DELETE);
                    o_cmd.fin       = 1'b1;
                    o_cmd.status    = ST_OK;
                    n_state         = S_DONE;
                end else if (i_stat.step_limit) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.status = ST_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.walk = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_INS: begin
                o_cmd.do_insert = 1'b1;
                o_cmd.fin       = 1'b1;
                o_cmd.status    = ST_OK;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.set_result = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/cht_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cht_dp
// datapath: bucket divider, chain stores, free stack and result register
// ----------------------------------------------------------------------------
module cht_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cht_pkg::t_cmd                 i_cmd,
    input  wire logic [cht_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [cht_pkg::KEY_W-1:0]     i_key,
    input  wire logic                          i_cfg_fire,
    input  wire logic [cht_pkg::BCNT_W-1:0]    i_cfg_data,
    input  wire logic                          i_out_ready,
    output cht_pkg::t_stat                     o_stat,
    output logic                               o_out_free,
    output logic                               o_out_valid,
    output logic [cht_pkg::STATUS_W-1:0]       o_status,
    output logic [cht_pkg::BUCKET_W-1:0]       o_bucket,
    output logic [cht_pkg::POS_W-1:0]          o_pos
);
    import cht_pkg::*;

    localparam int DIV_W  = BIDX_W + 1;
    localparam int STEP_W = $clog2(KEY_W + 1);

    logic [BCNT_W-1:0]    r_bcnt;
    logic [FUNC_W-1:0]    r_func;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [STEP_W-1:0]    r_mstep;
    logic [LINK_W-1:0]    r_cur, r_prev;
    logic [POS_W:0]       r_pos;
    logic [CNT_W-1:0]     r_free_total;
    logic [KEY_W-1:0]     r_rd_key;
    logic [LINK_W-1:0]    r_rd_link;
    logic [LINK_W-1:0]    r_heads [BUCKETS];
    logic [BUCKETS-1:0]   r_head_vld;
    logic [KEY_W-1:0]     r_node_keys  [NODES];
    logic [LINK_W-1:0]    r_node_links [NODES];
    logic [NIDX_W-1:0]    r_free_mem   [NODES];
    logic [NODES-1:0]     r_free_vld;
    logic [NIDX_W-1:0]    r_pop_mem;
    logic                 r_pop_vld;
    logic [NIDX_W-1:0]    r_pop_top;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_res_status;
    logic [POS_W-1:0]     r_res_pos;
    logic [STATUS_W-1:0]  r_status;
    logic [BUCKET_W-1:0]  r_bucket;
    logic [POS_W-1:0]     r_opos;
    logic [DIV_W:0]       w_trial;
    logic [DIV_W:0]       w_sub;
    logic [BIDX_W-1:0]    w_b;
    logic [LINK_W-1:0]    w_head;
    logic [NIDX_W-1:0]    w_cur_idx;
    logic [NIDX_W-1:0]    w_prev_idx;
    logic [NIDX_W-1:0]    w_new;
    logic [NIDX_W-1:0]    w_top_idx;
    logic [NIDX_W-1:0]    w_push_idx;
    logic                 w_lnk_we;
    logic [NIDX_W-1:0]    w_lnk_addr;
    logic [LINK_W-1:0]    w_lnk_data;

    // divider takes one quotient bit per cycle, msb first
    assign w_trial = {r_rem, r_quo[KEY_W-1]};
    assign w_sub   = w_trial - {1'b0, r_div};
    assign w_b     = r_rem[BIDX_W-1:0];
    assign w_head  = r_head_vld[w_b] ? r_heads[w_b] : NIL;
    assign w_cur_idx  = r_cur[NIDX_W-1:0];
    assign w_prev_idx = r_prev[NIDX_W-1:0];
    assign w_top_idx  = NIDX_W'(r_free_total - CNT_W'(1));
    assign w_new      = r_pop_vld ? r_pop_mem : r_pop_top;
    assign w_push_idx = r_free_total[NIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= BCNT_W'(BCNT_RESET);
        end else if (i_cfg_fire) begin
            r_bcnt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_quo   <= i_key;
            r_rem   <= '0;
            r_mstep <= '0;
            r_pos   <= '0;
            r_prev  <= NIL;
            if (r_bcnt == '0) begin
                r_div <= DIV_W'(1);
            end else if (r_bcnt > BCNT_W'(BUCKETS)) begin
                r_div <= DIV_W'(BUCKETS);
            end else begin
                r_div <= DIV_W'(r_bcnt);
            end
        end
        if (i_cmd.mod_step) begin
            r_quo   <= {r_quo[KEY_W-2:0], 1'b0};
            r_mstep <= r_mstep + STEP_W'(1);
            if (!w_sub[DIV_W]) begin
                r_rem <= w_sub[DIV_W-1:0];
            end else begin
                r_rem <= w_trial[DIV_W-1:0];
            end
        end
        if (i_cmd.head_rd) begin
            r_cur <= w_head;
        end
        if (i_cmd.walk) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_link;
            r_pos  <= r_pos + (POS_W+1)'(1);
        end
    end

    // single link write port
    always_comb begin
        w_lnk_we   = 1'b0;
        w_lnk_addr = w_cur_idx;
        w_lnk_data = NIL;
        if (i_cmd.do_insert) begin
            w_lnk_we   = 1'b1;
            w_lnk_addr = w_new;
            w_lnk_data = NIL;
        end else if (i_cmd.link_tail) begin
            w_lnk_we   = 1'b1;
            w_lnk_addr = w_cur_idx;
            w_lnk_data = {1'b0, w_new};
        end else if (i_cmd.do_delete && r_prev != NIL) begin
            w_lnk_we   = 1'b1;
            w_lnk_addr = w_prev_idx;
            w_lnk_data = r_rd_link;
        end
    end

    // node store
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_insert) begin
            r_node_keys[w_new] <= r_key;
        end
        if (w_lnk_we) begin
            r_node_links[w_lnk_addr] <= w_lnk_data;
        end
        if (i_cmd.node_rd) begin
            r_rd_key  <= r_node_keys[w_cur_idx];
            r_rd_link <= r_node_links[w_cur_idx];
        end
    end

    // free stack store, top entry read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_delete && r_free_total < CNT_W'(NODES)) begin
            r_free_mem[w_push_idx] <= w_cur_idx;
        end
        r_pop_mem <= r_free_mem[w_top_idx];
        r_pop_vld <= r_free_vld[w_top_idx];
        r_pop_top <= w_top_idx;
    end

    // bucket heads and free stack control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld   <= '0;
            r_free_vld   <= '0;
            r_free_total <= CNT_W'(NODES);
        end else begin
            if (i_cmd.do_insert) begin
                r_free_total <= r_free_total - CNT_W'(1);
                if (r_cur == NIL) begin
                    r_heads[w_b]    <= {1'b0, w_new};
                    r_head_vld[w_b] <= 1'b1;
                end
            end
            if (i_cmd.do_delete) begin
                if (r_prev == NIL) begin
                    r_heads[w_b]    <= r_rd_link;
                    r_head_vld[w_b] <= 1'b1;
                end
                if (r_free_total < CNT_W'(NODES)) begin
                    r_free_vld[w_push_idx] <= 1'b1;
                    r_free_total           <= r_free_total + CNT_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.set_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_res_status <= i_cmd.status;
            if (i_cmd.status != ST_OK) begin
                r_res_pos <= '0;
            end else if (i_cmd.do_insert && r_cur != NIL) begin
                r_res_pos <= POS_W'(r_pos + (POS_W+1)'(1));
            end else begin
                r_res_pos <= POS_W'(r_pos);
            end
        end
        if (i_cmd.set_result) begin
            r_status <= r_res_status;
            r_bucket <= BUCKET_W'(w_b);
            r_opos   <= r_res_pos;
        end
    end

    assign o_stat.mod_done   = (r_mstep == STEP_W'(KEY_W));
    assign o_stat.cur_nil    = (r_cur == NIL);
    assign o_stat.next_nil   = r_rd_link[LINK_W-1];
    assign o_stat.key_match  = (r_rd_key == r_key);
    assign o_stat.pool_empty = (r_free_total == '0);
    assign o_stat.step_limit = (r_pos == (POS_W+1)'(NODES - 1));
    assign o_stat.func       = r_func;

    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_bucket    = r_bucket;
    assign o_pos       = r_opos;

endmodule
`default_nettype wire

/* sv/chained_hash_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// hash table with separate chaining over a bounded node pool
// ----------------------------------------------------------------------------
// channel   direction  signals
// request   in         i_valid / o_ready, i_func, i_key
// result    out        o_valid / i_ready, o_status, o_bucket, o_chain_position
// config    in         i_cfg_valid / o_cfg_ready, i_cfg_data (bucket_count)
//
// one request at a time: after acceptance the divider reduces the key to a bucket,
// the bucket head is read, each chain entry visited is read and checked, an insert
// commits its node, and the result is posted; a full pool skips the walk, and a
// none request posts no result; the bucket divider (one bit per cycle) and the
// single-port node walk set the pace; synchronous active-low reset clears heads and
// the free stack at once; a finished result waits in the output register; the next
// request is taken
module chained_hash_table_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [cht_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [cht_pkg::KEY_W-1:0]   i_key,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [cht_pkg::STATUS_W-1:0]     o_status,
    output logic [cht_pkg::BUCKET_W-1:0]     o_bucket,
    output logic [cht_pkg::POS_W-1:0]        o_chain_position,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [cht_pkg::BCNT_W-1:0]  i_cfg_data
);
    import cht_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_busy;
    logic  w_out_free;

    assign o_ready     = !w_busy;
    assign o_cfg_ready = 1'b1;

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_fire (i_valid && !w_busy),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    cht_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_cfg_fire  (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_free  (w_out_free),
        .o_out_valid (o_valid),
        .o_status    (o_status),
        .o_bucket    (o_bucket),
        .o_pos       (o_chain_position)
    );

endmodule
`default_nettype wire
